// ----- rtl/core/heat_stencil_gaussian_source_unit_macros.svh -----
// Assertion macros shared by the checker of the heat stencil unit.
// Needs clk and rst_n in the scope of each use.
`ifndef HEAT_STENCIL_GAUSSIAN_SOURCE_UNIT_MACROS_SVH
`define HEAT_STENCIL_GAUSSIAN_SOURCE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSG_AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heat stencil check failed");

// next-cycle implication, checked outside reset
`define HSG_AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heat stencil check failed");

`endif

// ----- rtl/core/hsg_pkg.sv -----
// Package of the heat stencil unit: word types, register codes, exp table math.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsg_pkg;

  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int WHOLE_DEPTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_X      = 3'd0,
    CFG_BEAM_Y      = 3'd1,
    CFG_BEAM_Z      = 3'd2,
    CFG_DIFF_GAIN   = 3'd3,
    CFG_SRC_AMP     = 3'd4,
    CFG_INV_RSQ_X   = 3'd5,
    CFG_INV_RSQ_Y   = 3'd6,
    CFG_INV_RSQ_Z   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        centre_temp;
    logic [31:0]        west_temp;
    logic [31:0]        east_temp;
    logic [31:0]        south_temp;
    logic [31:0]        north_temp;
    logic [31:0]        below_temp;
    logic [31:0]        above_temp;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
  } in_word_t;

  typedef struct packed {
    logic [31:0] new_temp;
    logic        clipped;
  } out_word_t;

  // one axis share of the exponent, Q4.32, sat = share is 16.0 or more
  typedef struct packed {
    logic        sat;
    logic [35:0] term;
  } axis_term_t;

  // exp(-x), x in Q0.32, 21-term Taylor series, result Q1.31 (elaboration only)
  function automatic logic [63:0] exp_series_q31(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 32;
    pos  = term;
    neg  = 64'd0;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return ((pos - neg) + 64'd1) >> 1;
  endfunction

  // exp(-n) in Q1.31 as repeated rounded products of exp(-1)
  function automatic logic [31:0] exp_whole_q31(input int n);
    logic [63:0] h;
    logic [63:0] e1;
    logic [63:0] w;
    h  = exp_series_q31(64'd1 << 31);
    e1 = (h * h + (64'd1 << 30)) >> 31;
    w  = 64'd1 << 31;
    for (int i = 0; i < n; i++) begin
      w = (w * e1 + (64'd1 << 30)) >> 31;
    end
    return w[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hsg_stencil.sv -----
// Laplacian and diffusion scaling, delayed to line up with the source path.
// Uses hsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsg_stencil (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire hsg_pkg::in_word_t  in_word,
  input  wire logic [31:0]        gain,
  output logic [31:0]             centre_q,
  output logic signed [35:0]      lap_q
);
  import hsg_pkg::*;

  localparam int DLY = 7;

  logic [34:0]        nsum;
  logic [34:0]        cw;
  logic signed [35:0] lap1_r;
  logic [31:0]        c1_r;
  logic [34:0]        mag;
  logic [66:0]        prod;
  logic [34:0]        scaled;
  logic signed [35:0] lap2_r;
  logic [31:0]        c2_r;
  logic signed [35:0] dly_lap_r [DLY];
  logic [31:0]        dly_c_r   [DLY];

  assign nsum = 35'(in_word.west_temp) + 35'(in_word.east_temp)
              + 35'(in_word.south_temp) + 35'(in_word.north_temp)
              + 35'(in_word.below_temp) + 35'(in_word.above_temp);
  assign cw   = {2'b00, in_word.centre_temp, 1'b0} + {1'b0, in_word.centre_temp, 2'b00};

  assign mag    = lap1_r[35] ? 35'(-lap1_r) : lap1_r[34:0];
  assign prod   = 67'(mag) * 67'(gain);
  assign scaled = prod[66:32];

  always_ff @(posedge clk) begin
    if (en) begin
      lap1_r <= $signed({1'b0, nsum}) - $signed({1'b0, cw});
      c1_r   <= in_word.centre_temp;
      lap2_r <= lap1_r[35] ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
      c2_r   <= c1_r;
      dly_lap_r[0] <= lap2_r;
      dly_c_r[0]   <= c2_r;
      for (int i = 1; i < DLY; i++) begin
        dly_lap_r[i] <= dly_lap_r[i-1];
        dly_c_r[i]   <= dly_c_r[i-1];
      end
    end
  end

  assign lap_q    = dly_lap_r[DLY-1];
  assign centre_q = dly_c_r[DLY-1];
endmodule
`default_nettype wire

// ----- rtl/core/hsg_axis.sv -----
// One axis share of the Gaussian exponent: |d|, d^2, split product, cap.
// Uses hsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsg_axis (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [31:0]  cell_pos,
  input  wire logic signed [31:0]  beam,
  input  wire logic [39:0]         inv,
  output hsg_pkg::axis_term_t      term_q
);
  import hsg_pkg::*;

  logic signed [32:0] diff;
  logic [32:0]        d_r;
  logic [64:0]        d2_r;
  logic [63:0]        pp0_r;
  logic [64:0]        pp1_r;
  logic [39:0]        pp2_r;
  logic               hi_r;
  logic [97:0]        full;
  axis_term_t         term_r;

  assign diff = 33'(cell_pos) - 33'(beam);
  // pp1 + pp2 shifted up by 32, plus pp0
  assign full = ((98'(pp1_r) + 98'(pp2_r)) << 32) + 98'(pp0_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= diff[32] ? 33'(-diff) : 33'(diff);
      d2_r  <= 65'(66'(d_r) * 66'(d_r));
      pp0_r <= 64'(d2_r[31:0]) * 64'(inv[31:0]);
      pp1_r <= 65'(d2_r[64:32]) * 65'(inv[31:0]);
      pp2_r <= 40'(d2_r[31:0]) * 40'(inv[39:32]);
      hi_r  <= (|d2_r[64:32]) && (|inv[39:32]);
      term_r.sat  <= hi_r || (|full[97:64]);
      term_r.term <= full[63:28];
    end
  end

  assign term_q = term_r;
endmodule
`default_nettype wire

// ----- rtl/core/hsg_exp.sv -----
// Exponent sum, exp lookup in whole and fraction ROMs, amplitude scaling.
// Uses hsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsg_exp #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire hsg_pkg::axis_term_t term_x,
  input  wire hsg_pkg::axis_term_t term_y,
  input  wire hsg_pkg::axis_term_t term_z,
  input  wire logic [31:0]         amplitude,
  output logic [31:0]              src_q
);
  import hsg_pkg::*;

  localparam int KW = $clog2(EXP_TABLE_DEPTH);

  logic [31:0] frac_rom  [EXP_TABLE_DEPTH];
  logic [31:0] whole_rom [WHOLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_frac
    localparam logic [63:0] X = (64'(k) << 32) / EXP_TABLE_DEPTH;
    assign frac_rom[k] = 32'(exp_series_q31(X));
  end
  for (genvar n = 0; n < WHOLE_DEPTH; n++) begin : g_whole
    assign whole_rom[n] = exp_whole_q31(n);
  end

  logic [37:0] f_r;
  logic        kill1_r;
  logic [3:0]  n_r;
  logic [KW-1:0] k_r;
  logic        kill2_r;
  logic [31:0] w_r;
  logic [31:0] fr_r;
  logic        kill3_r;
  logic [31:0] g_r;
  logic        kill4_r;
  logic [31:0] src_r;
  logic [63:0] kprod;
  logic [63:0] gprod;
  logic [63:0] sprod;

  assign kprod = 64'(f_r[31:0]) * 64'(EXP_TABLE_DEPTH);
  assign gprod = 64'(w_r) * 64'(fr_r);
  assign sprod = 64'(amplitude) * 64'(g_r);

  always_ff @(posedge clk) begin
    if (en) begin
      f_r     <= 38'(term_x.term) + 38'(term_y.term) + 38'(term_z.term);
      kill1_r <= term_x.sat || term_y.sat || term_z.sat;
      // sum of 16.0 or more kills the source
      kill2_r <= kill1_r || (|f_r[37:36]);
      n_r     <= f_r[35:32];
      k_r     <= kprod[32 +: KW];
      w_r     <= whole_rom[n_r];
      fr_r    <= frac_rom[k_r];
      kill3_r <= kill2_r;
      g_r     <= gprod[62:31];
      kill4_r <= kill3_r;
      src_r   <= kill4_r ? 32'd0 : sprod[62:31];
    end
  end

  assign src_q = src_r;
endmodule
`default_nettype wire

// ----- rtl/core/heat_stencil_gaussian_source_unit.sv -----
// Explicit 3D heat update of one grid cell per word, with a Gaussian beam source.
// A word carries the cell temperature, its six face neighbours and the cell
// position; the result word is centre + gain * (neighbours - 6 * centre) +
// amplitude * exp(-sum of d^2 / r^2), saturated to 32 bits with a clip flag.
// The unit is a 10-stage pipeline from an accepted input word to out_valid, and
// one word is taken every cycle unless the pipe holds. All stages advance
// together; while a result waits on out_stall the whole pipe holds, so
// in_stall follows out_stall when the output register is full. Exponent path:
// |d|, d^2, split partial products of d^2 * 1/r^2, cap, sum, table index,
// ROM read, whole*fraction product, amplitude product. The Laplacian path runs
// alongside and is delayed to meet it. There is no read-back. Registers are to
// be written by the user through cfg_* while the unit holds no word; unenforced.
// Depends on hsg_pkg, hsg_stencil, hsg_axis, hsg_exp.
`timescale 1ns / 1ps
`default_nettype none
module heat_stencil_gaussian_source_unit #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire hsg_pkg::in_word_t                 in_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output hsg_pkg::out_word_t                     out_word,
  input  wire logic                              cfg_we,
  input  wire logic [hsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hsg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hsg_pkg::*;

  localparam int LAT = 10;

  // configuration registers
  logic signed [31:0] beam_x_r, beam_y_r, beam_z_r;
  logic [31:0]        gain_r, amp_r;
  logic [39:0]        inv_x_r, inv_y_r, inv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_x_r <= '0;
      beam_y_r <= '0;
      beam_z_r <= '0;
      gain_r   <= '0;
      amp_r    <= '0;
      inv_x_r  <= '0;
      inv_y_r  <= '0;
      inv_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BEAM_X:    beam_x_r <= cfg_data[31:0];
        CFG_BEAM_Y:    beam_y_r <= cfg_data[31:0];
        CFG_BEAM_Z:    beam_z_r <= cfg_data[31:0];
        CFG_DIFF_GAIN: gain_r   <= cfg_data[31:0];
        CFG_SRC_AMP:   amp_r    <= cfg_data[31:0];
        CFG_INV_RSQ_X: inv_x_r  <= cfg_data;
        CFG_INV_RSQ_Y: inv_y_r  <= cfg_data;
        CFG_INV_RSQ_Z: inv_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advance: output register empty or being taken
  logic en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // datapaths
  logic [31:0]        centre_q;
  logic signed [35:0] lap_q;
  axis_term_t         tx, ty, tz;
  logic [31:0]        src_q;

  hsg_stencil u_stencil (
    .clk      (clk),
    .en       (en),
    .in_word  (in_word),
    .gain     (gain_r),
    .centre_q (centre_q),
    .lap_q    (lap_q)
  );

  hsg_axis u_axis_x (
    .clk(clk), .en(en), .cell_pos(in_word.cell_x), .beam(beam_x_r), .inv(inv_x_r), .term_q(tx)
  );
  hsg_axis u_axis_y (
    .clk(clk), .en(en), .cell_pos(in_word.cell_y), .beam(beam_y_r), .inv(inv_y_r), .term_q(ty)
  );
  hsg_axis u_axis_z (
    .clk(clk), .en(en), .cell_pos(in_word.cell_z), .beam(beam_z_r), .inv(inv_z_r), .term_q(tz)
  );

  hsg_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk       (clk),
    .en        (en),
    .term_x    (tx),
    .term_y    (ty),
    .term_z    (tz),
    .amplitude (amp_r),
    .src_q     (src_q)
  );

  // final sum and saturation into the output register
  logic signed [37:0] total;
  out_word_t          out_r;
  out_word_t          out_nxt;

  assign total = $signed({6'd0, centre_q}) + 38'(lap_q) + $signed({6'd0, src_q});

  always_comb begin
    priority if (total < 0) begin
      out_nxt.new_temp = '0;
      out_nxt.clipped  = 1'b1;
    end else if (|total[37:32]) begin
      out_nxt.new_temp = '1;
      out_nxt.clipped  = 1'b1;
    end else begin
      out_nxt.new_temp = total[31:0];
      out_nxt.clipped  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_word  = out_r;
endmodule
`default_nettype wire

// ----- rtl/core/hsg_checker.sv -----
// Port-level checks of the heat stencil unit, bound to the top level.
// Uses hsg_pkg and heat_stencil_gaussian_source_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "heat_stencil_gaussian_source_unit_macros.svh"
module hsg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire hsg_pkg::out_word_t                out_word
);
  import hsg_pkg::*;

  `HSG_AST_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `HSG_AST_NXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  `HSG_AST_IMP(a_clip_rail, out_valid && out_word.clipped, ~|out_word.new_temp || &out_word.new_temp)
  `HSG_AST_IMP(a_stall_cause, in_stall, out_valid && out_stall)
endmodule

bind heat_stencil_gaussian_source_unit hsg_checker u_hsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

// ----- test/heat_stencil_checker.sv -----
// Scoreboard for the heat stencil unit: mirrors the register writes, predicts
// each new cell temperature and compares the accepted result words in order.
// Depends on hsg_pkg for the word types and register codes.
`timescale 1ns / 1ps
module heat_stencil_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  hsg_pkg::in_word_t             in_word,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  hsg_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [hsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            temps_due
);
  import hsg_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [63:0] EXP_CAP = 64'd16 << 32;

  logic [63:0] frac_rom [DEPTH];
  logic [63:0] whole_rom [16];

  logic signed [31:0] bx, by, bz;
  logic [31:0] gain, amp;
  logic [39:0] irx, iry, irz;

  out_word_t temp_q[$];

  // exp(-x), x in Q0.32, Taylor sum with per-term truncation, back to Q1.31
  function automatic logic [63:0] taylor_exp(input logic [63:0] x);
    logic [63:0] t, up, dn;
    t = 64'd1 << 32;
    up = t;
    dn = 0;
    for (int n = 1; n <= 20; n++) begin
      t = ((t * x) >> 32) / n;
      if (n & 1) dn += t;
      else up += t;
    end
    return ((up - dn) + 1) >> 1;
  endfunction

  initial begin
    logic [63:0] half, e1;
    for (int k = 0; k < DEPTH; k++) frac_rom[k] = taylor_exp((64'(k) << 32) / DEPTH);
    half = taylor_exp(64'd1 << 31);
    e1 = (half * half + (64'd1 << 30)) >> 31;
    whole_rom[0] = 64'd1 << 31;
    for (int k = 1; k < 16; k++)
      whole_rom[k] = (whole_rom[k-1] * e1 + (64'd1 << 30)) >> 31;
  end

  // squared distance over squared radius along one axis, Q.32, capped
  function automatic logic [63:0] axis_share(input logic signed [31:0] c,
                                             input logic signed [31:0] b,
                                             input logic [39:0] inv);
    logic signed [63:0] diff;
    logic [63:0] d, d2;
    logic [127:0] p;
    diff = 64'(c) - 64'(b);
    d = diff < 0 ? -diff : diff;
    d2 = d * d;
    p = 128'(d2) * 128'(inv);
    if (p[127:64] != 0) return EXP_CAP;
    return 64'(p[63:28]);
  endfunction

  function automatic out_word_t next_temp(input in_word_t w);
    logic [63:0] nsum, mag, scaled, f, g, src, k;
    logic signed [63:0] lap, lap_s, total;
    out_word_t r;
    nsum = 64'(w.west_temp) + w.east_temp + w.south_temp + w.north_temp
         + w.below_temp + w.above_temp;
    lap = $signed(nsum) - $signed(64'(w.centre_temp) * 6);
    mag = lap < 0 ? -lap : lap;
    scaled = (mag >> 32) * gain + ((64'(mag[31:0]) * gain) >> 32);
    lap_s = lap < 0 ? -$signed(scaled) : $signed(scaled);
    f = axis_share(w.cell_x, bx, irx) + axis_share(w.cell_y, by, iry)
      + axis_share(w.cell_z, bz, irz);
    src = 0;
    if (f < EXP_CAP) begin
      k = (64'(f[31:0]) * DEPTH) >> 32;
      g = (whole_rom[f[35:32]] * frac_rom[k]) >> 31;
      src = (64'(amp) * g) >> 31;
    end
    total = $signed(64'(w.centre_temp)) + lap_s + $signed(src);
    if (total < 0) r = '{new_temp: 32'd0, clipped: 1'b1};
    else if (total > 64'hFFFF_FFFF) r = '{new_temp: 32'hFFFF_FFFF, clipped: 1'b1};
    else r = '{new_temp: total[31:0], clipped: 1'b0};
    return r;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH t=%0t %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign temps_due = temp_q.size();

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      {bx, by, bz, gain, amp, irx, iry, irz} = '0;
      temp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (temp_q.size() == 0) report("result word with none expected");
        else begin
          want = temp_q.pop_front();
          if (out_word.new_temp !== want.new_temp)
            report($sformatf("new_temp %h want %h", out_word.new_temp, want.new_temp));
          if (out_word.clipped !== want.clipped)
            report($sformatf("clipped %b want %b", out_word.clipped, want.clipped));
        end
      end
      if (in_valid && !in_stall) temp_q.push_back(next_temp(in_word));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BEAM_X:    bx = cfg_data[31:0];
          CFG_BEAM_Y:    by = cfg_data[31:0];
          CFG_BEAM_Z:    bz = cfg_data[31:0];
          CFG_DIFF_GAIN: gain = cfg_data[31:0];
          CFG_SRC_AMP:   amp = cfg_data[31:0];
          CFG_INV_RSQ_X: irx = cfg_data;
          CFG_INV_RSQ_Y: iry = cfg_data;
          CFG_INV_RSQ_Z: irz = cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- test/tb.sv -----
// Top of the heat stencil unit testbench: clock, reset, register setup,
// directed and random cell words, output backpressure and the verdict.
// Depends on hsg_pkg, heat_stencil_gaussian_source_unit, heat_stencil_checker.
`timescale 1ns / 1ps
module tb;
  import hsg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PIPE_DRAIN = 20;     // pipe is 10 deep; margin on top

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_word;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, temps_due, cycles = 0;
  bit hold_req = 0;          // ask the receiver for one long hold-off
  int hold_left = 0, stall_left = 0, calm_left = 0;

  // beam position of the current setting, to aim cells near it
  logic signed [31:0] aim_x, aim_y, aim_z;

  heat_stencil_gaussian_source_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_data
  );

  heat_stencil_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .temps_due
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: short random stalls, some long ones, calm stretches without
  // any, and on request one long hold-off so the pipe backs up into in_stall.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 0;
    else if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= hold_left > 0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  out_stall <= 0;
        [60:89]: out_stall <= 1;
        [90:95]: stall_left = $urandom_range(5, 40);
        default: calm_left = $urandom_range(50, 200);
      endcase
    end
  end

  // write a full register setting; unit must be empty
  task automatic load_regs(input logic [31:0] x, y, z, g, a,
                           input logic [39:0] rx, ry, rz);
    logic [CFG_DATA_W-1:0] vals [8];
    vals = '{{8'($urandom), x}, {8'($urandom), y}, {8'($urandom), z},
             {8'($urandom), g}, {8'($urandom), a}, rx, ry, rz};
    in_valid <= 0;
    wait (temps_due == 0);
    repeat (PIPE_DRAIN) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    aim_x = x;
    aim_y = y;
    aim_z = z;
  endtask

  // offer one word and hold it until taken; returns at a falling edge
  task automatic send_word(input in_word_t w);
    in_valid <= 1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    case ($urandom_range(0, 99)) inside
      [0:59]:  n = 0;
      [60:92]: n = $urandom_range(1, 3);
      default: n = $urandom_range(10, 40);
    endcase
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] edge32();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic in_word_t random_cell();
    in_word_t w;
    logic [31:0] base;
    int spread;
    case ($urandom_range(0, 9)) inside
      [0:5]: begin
        // plausible field: neighbours near the centre, cell near the beam
        base = $urandom;
        spread = 1 << $urandom_range(4, 24);
        w.centre_temp = base;
        w.west_temp  = base + $urandom_range(0, spread) - spread / 2;
        w.east_temp  = base + $urandom_range(0, spread) - spread / 2;
        w.south_temp = base + $urandom_range(0, spread) - spread / 2;
        w.north_temp = base + $urandom_range(0, spread) - spread / 2;
        w.below_temp = base + $urandom_range(0, spread) - spread / 2;
        w.above_temp = base + $urandom_range(0, spread) - spread / 2;
        spread = 1 << $urandom_range(2, 16);
        w.cell_x = aim_x + $urandom_range(0, spread) - spread / 2;
        w.cell_y = aim_y + $urandom_range(0, spread) - spread / 2;
        w.cell_z = aim_z + $urandom_range(0, spread) - spread / 2;
      end
      [6:7]: w = {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom};
      default: w = {edge32(), edge32(), edge32(), edge32(), edge32(),
                    edge32(), edge32(), edge32(), edge32(), edge32()};
    endcase
    return w;
  endfunction

  function automatic in_word_t make_cell(input logic [31:0] c, nb,
                                         input logic signed [31:0] x, y, z);
    return '{c, nb, nb, nb, nb, nb, nb, x, y, z};
  endfunction

  logic [39:0] rsq;

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    aim_x = 0; aim_y = 0; aim_z = 0;

    // reset setting: no gain, no source, word passes through
    send_word(make_cell(32'h1234_5678, 32'hFFFF_FFFF, 0, 0, 0));
    send_word(make_cell(32'hFFFF_FFFF, 32'h0, 32'sh7FFF_FFFF, 0, 0));

    // full gain and amplitude, steep beam: an axis share saturates beyond 4096 nm
    load_regs(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF,
              40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_word(make_cell(0, 0, 0, 0, 0));                        // all zero, peak source
    send_word(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0)); // clips high
    send_word(make_cell(32'hFFFF_FFFF, 0, 9000, 0, 0));         // Laplacian clips low
    send_word(make_cell(0, 32'hFFFF_FFFF, 9000, 9000, 9000));   // neighbours push high
    send_word(make_cell(32'h0100_0000, 32'h0100_0001, 9000, 0, 0)); // tiny Laplacian
    send_word(make_cell(32'h0100_0000, 32'h00FF_FFFF, 9000, 0, 0)); // truncation toward 0
    send_word(make_cell(32'h1000_0000, 32'h1000_0000, 4095, 0, 0)); // axis just below cap
    send_word(make_cell(32'h1000_0000, 32'h1000_0000, 4096, 0, 0)); // axis share at the largest value below cap
    send_word(make_cell(32'h1000_0000, 32'h1000_0000, 2400, 2400, 2400)); // sum over cap
    send_word(make_cell(32'h1000_0000, 32'h1000_0000, 1000, 1500, 2000));
    send_word(make_cell(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1));

    // beam at the most negative corner; cells at the far corner (largest distance) and nearer
    load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF,
              40'd1, 40'd1, 40'd1);
    send_word(make_cell(32'h4000_0000, 32'h0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF));
    send_word(make_cell(32'h4000_0000, 32'h0, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000));
    send_word(make_cell(32'h4000_0000, 32'h0, 32'sh8000_0000, 32'sh8000_1000, 0));

    // zero inverse radius terms: exponent is zero everywhere
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000,
              0, 0, 0);
    send_word(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 0, 0));
    send_word(make_cell(32'h0001_0000, 32'h0, 1, 2, 3));

    // random phases; x inverse squared radius a power of two from 2^24 to 2^39, else random
    for (int ph = 0; ph < 8; ph++) begin
      rsq = $urandom_range(0, 7) == 0 ? {8'($urandom), 32'($urandom)}
                                      : 40'(64'd1 << $urandom_range(24, 39));
      load_regs($urandom, $urandom, $urandom,
                ph == 2 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h4000_0000),
                ph == 3 ? 32'hFFFF_FFFF : $urandom,
                rsq, rsq >> $urandom_range(0, 3), rsq << $urandom_range(0, 1));
      for (int i = 0; i < 250; i++) begin
        if (ph == 3 && i == 40) hold_req = 1;   // long hold-off, sender keeps on
        if (ph == 5 && i == 125) begin           // sender waits for a full drain
          in_valid <= 0;
          wait (temps_due == 0);
          @(negedge clk);
        end
        send_word(random_cell());
        sender_gap();
      end
    end

    in_valid <= 0;
    wait (temps_due == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
